### design/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

  localparam logic [7:0] STAR_SYM = 8'd42;
  localparam logic [7:0] ANY_SYM  = 8'd63;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_BEGIN  = 2'd2,
    FUNC_TEXT   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       wr;      // append write, lands in the cell at index count
    logic [7:0] wr_sym;  // byte being appended
    logic       text;    // wave is a text update, else an empty-row load
    logic [7:0] key;     // text byte of the running wave
  } bcast_t;

endpackage

### design/wpm_if.sv
// Valid/ready channel interfaces for the input and result words.
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [6:0] pattern_length;
  logic       dropped;

  modport source (output valid, output matched, output pattern_length,
                  output dropped, input ready);
  modport sink   (input valid, input matched, input pattern_length,
                  input dropped, output ready);
endinterface

### design/wpm_cell.sv
// One pattern position: stored byte, its match bit and the wave hand-off.
module wpm_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpm_pkg::bcast_t    bc,
  input  logic [CNT_W-1:0]   count,
  input  logic               tok_in,
  input  logic               new_in,
  input  logic               old_in,
  output logic               tok_out,
  output logic               new_out,
  output logic               old_out,
  output logic               hit
);
  import wpm_pkg::*;

  logic [7:0] sym_r;
  logic       match_r;
  logic       tok_r;
  logic       hand_new_r;
  logic       hand_old_r;
  logic       active;
  logic       match_nxt;

  assign active = count > CNT_W'(IDX);

  always_comb begin
    if (bc.text) begin
      if (sym_r == bc.key || sym_r == ANY_SYM) begin
        match_nxt = old_in;
      end else if (sym_r == STAR_SYM) begin
        match_nxt = old_in | new_in | match_r;
      end else begin
        match_nxt = 1'b0;
      end
    end else begin
      // empty-text row: run of leading stars
      match_nxt = new_in & (sym_r == STAR_SYM);
    end
  end

  always_ff @(posedge clk) begin
    if (bc.wr && count == CNT_W'(IDX)) begin
      sym_r <= bc.wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in & active;
      if (tok_in && active) begin
        match_r <= match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in && active) begin
      hand_new_r <= match_nxt;
      hand_old_r <= match_r;
    end
  end

  assign tok_out = tok_r;
  assign new_out = hand_new_r;
  assign old_out = hand_old_r;
  assign hit     = match_r & (count == CNT_W'(IDX + 1));

endmodule

### design/wildcard_pattern_matcher.sv
// Top level: glob matcher built as a chain of pattern-position cells.
//
// in_ch carries words of func and symbol: clear pattern, append a pattern
// byte, begin a new text, or a text byte. Every accepted word yields one
// result word on out_ch: whether the text since the last begin matches the
// whole pattern, the stored pattern length, and a drop flag for an append
// that found the store full.
// A word that touches the match row (append, or begin or text byte with a
// non-empty pattern) starts a wave that walks the cell chain one cell per
// cycle; clear, a dropped append, and begin or text byte with an empty
// pattern go straight to the result stage. The result is registered.
// The next word is accepted while a result still waits in the output
// register; if that register is still full when a word is finished, the
// block holds until the receiver takes the waiting word.
// Reset (rst_n low, synchronous) empties the pattern, sets the row to the
// empty-text row and drops any pending result.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  wpm_in_if.sink   in_ch,
  wpm_out_if.source out_ch
);
  import wpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int EXT_W = CNT_W + 7;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             match0_r, match0_nxt;
  logic             tok_head_r, tok_head_nxt;
  logic             head_new_r, head_new_nxt;
  logic             head_old_r, head_old_nxt;
  logic             text_r, text_nxt;
  logic [7:0]       key_r, key_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r;
  logic [6:0]       out_len_r;
  logic             out_drop_r;
  logic             out_load;
  logic             accept;
  logic             wr;
  logic             full;
  logic             matched;
  logic [EXT_W-1:0] len_ext;
  func_t            func;
  bcast_t           bc;

  logic [MAX_PATTERN:0]   tok_w;
  logic [MAX_PATTERN:0]   new_w;
  logic [MAX_PATTERN:0]   old_w;
  logic [MAX_PATTERN-1:0] hit_w;

  assign func   = func_t'(in_ch.func);
  assign accept = in_ch.valid && in_ch.ready;
  assign full   = count_r == CNT_W'(MAX_PATTERN);
  assign in_ch.ready = state_r == ST_IDLE;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    match0_nxt    = match0_r;
    tok_head_nxt  = 1'b0;
    head_new_nxt  = head_new_r;
    head_old_nxt  = head_old_r;
    text_nxt      = text_r;
    key_nxt       = key_r;
    drop_nxt      = drop_r;
    wr            = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          drop_nxt     = 1'b0;
          step_nxt     = CNT_W'(1);
          text_nxt     = 1'b0;
          head_new_nxt = 1'b1;
          head_old_nxt = match0_r;
          key_nxt      = in_ch.symbol;
          state_nxt    = ST_FIN;
          unique case (func)
            FUNC_CLEAR: begin
              count_nxt  = '0;
              match0_nxt = 1'b1;
            end
            FUNC_APPEND: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                wr           = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                match0_nxt   = 1'b1;
                tok_head_nxt = 1'b1;
                state_nxt    = ST_RUN;
              end
            end
            FUNC_BEGIN: begin
              match0_nxt = 1'b1;
              if (count_r != '0) begin
                tok_head_nxt = 1'b1;
                state_nxt    = ST_RUN;
              end
            end
            FUNC_TEXT: begin
              match0_nxt   = 1'b0;
              text_nxt     = 1'b1;
              head_new_nxt = 1'b0;
              if (count_r != '0) begin
                tok_head_nxt = 1'b1;
                state_nxt    = ST_RUN;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_RUN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == count_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      match0_r    <= 1'b1;
      tok_head_r  <= 1'b0;
      text_r      <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      match0_r    <= match0_nxt;
      tok_head_r  <= tok_head_nxt;
      text_r      <= text_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_new_r <= head_new_nxt;
    head_old_r <= head_old_nxt;
    key_r      <= key_nxt;
    if (out_load) begin
      out_matched_r <= matched;
      out_len_r     <= len_ext[6:0];
      out_drop_r    <= drop_r;
    end
  end

  assign bc.wr     = wr;
  assign bc.wr_sym = in_ch.symbol;
  assign bc.text   = text_r;
  assign bc.key    = key_r;

  assign tok_w[0] = tok_head_r;
  assign new_w[0] = head_new_r;
  assign old_w[0] = head_old_r;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    wpm_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bc      (bc),
      .count   (count_r),
      .tok_in  (tok_w[g]),
      .new_in  (new_w[g]),
      .old_in  (old_w[g]),
      .tok_out (tok_w[g+1]),
      .new_out (new_w[g+1]),
      .old_out (old_w[g+1]),
      .hit     (hit_w[g])
    );
  end

  // at most one cell sits at the pattern end
  assign matched = (count_r == '0) ? match0_r : |hit_w;
  assign len_ext = EXT_W'(count_r);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.matched        = out_matched_r;
  assign out_ch.pattern_length = out_len_r;
  assign out_ch.dropped        = out_drop_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern count beyond store size");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> count_r != '0 && step_r <= count_r)
    else $error("wave running past pattern end");

  a_head_start: assert property (@(posedge clk) disable iff (!rst_n)
    tok_head_r |-> state_r == ST_RUN && step_r == CNT_W'(1))
    else $error("wave token without run start");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func == FUNC_CLEAR |=> count_r == '0 && match0_r)
    else $error("clear did not empty pattern");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_matched_r))
    else $error("pending result overwritten");
`endif

endmodule
